[rtl/bfha_pkg.sv]
// Shared types and constants for the best-fit heap allocator.
// No dependencies; used by every module under rtl/ except bfha_queue.
package bfha_pkg;

   localparam int DEF_HEAP_BYTES    = 65536;
   localparam int DEF_MAX_FREE_SEGS = 64;
   localparam int DEF_MIN_SPLIT     = 12;

   localparam int ADDR_W   = 32;
   localparam int SIZE_W   = 32;
   localparam int FREE_W   = 17;
   localparam int STATUS_W = 2;
   localparam int CSR_W    = 32;

   localparam logic [CSR_W-1:0] HEAP_BASE_RST  = 32'h1000_0000;
   localparam logic [CSR_W-1:0] HEAP_LIMIT_RST = 32'h1001_0000;

   typedef enum logic {
      CSR_HEAP_BASE  = 1'b0,
      CSR_HEAP_LIMIT = 1'b1
   } csr_idx_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NO_SPACE   = 2'd1,
      STATUS_OUTSIDE    = 2'd2,
      STATUS_TABLE_FULL = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      KIND_NULL    = 3'd0,
      KIND_FREE    = 3'd1,
      KIND_REALLOC = 3'd2,
      KIND_ALLOC   = 3'd3,
      KIND_BAD     = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type kind;
      logic     first;
   } ctl_type;

endpackage

[rtl/best_fit_heap_allocator.sv]
// From accept to result the sequencer scans the segment table and shifts entries on
//   unlink/insert; a realloc that moves runs a second scan for the free.
// Throughput: one request in flight in the sequencer; the table memory port sets the pace.
// The front end takes the next beat while the back end works; results wait in an output reg.
// Reset is synchronous; segment table and size store have no clearing pass, the first
//   request after reset latches base/limit and seeds the table.
module best_fit_heap_allocator #(
   parameter int HEAP_BYTES    = bfha_pkg::DEF_HEAP_BYTES,
   parameter int MAX_FREE_SEGS = bfha_pkg::DEF_MAX_FREE_SEGS,
   parameter int MIN_SPLIT     = bfha_pkg::DEF_MIN_SPLIT
) (
   input  logic         clock,
   input  logic         reset,
   // config write port
   input  logic         csr_we,
   input  logic         csr_addr,
   input  logic [31:0]  csr_wdata,
   // request beat
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // block_addr[31:0], req_size[63:32]
   input  logic         req_tuser,   // has_block
   // result beat
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [55:0]  rsp_tdata    // status[1:0], result_addr[33:2], moved[34],
                                     // free_bytes[51:35], zero[55:52]
);

   localparam int OFF_W  = $clog2(HEAP_BYTES + 1);
   localparam int NEED_W = OFF_W + 1;
   localparam int QW     = $bits(bfha_pkg::ctl_type) + bfha_pkg::ADDR_W + OFF_W + NEED_W;

   bfha_pkg::ctl_type            f_ctl, b_ctl;
   logic [bfha_pkg::ADDR_W-1:0]  f_addr, b_addr, base_latch;
   logic [OFF_W-1:0]             f_hdr, b_hdr, span_latch;
   logic [NEED_W-1:0]            f_need, b_need;
   logic                         push, push_ready, q_valid, q_pop;
   logic [QW-1:0]                q_out;
   logic [bfha_pkg::STATUS_W-1:0] r_status;
   logic [bfha_pkg::ADDR_W-1:0]  r_addr;
   logic                         r_moved;
   logic [bfha_pkg::FREE_W-1:0]  r_free;

   bfha_front #(.HEAP_BYTES(HEAP_BYTES)) u_front (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .has_block(req_tuser), .block_addr(req_tdata[31:0]), .req_size(req_tdata[63:32]),
      .push(push), .push_ready(push_ready),
      .push_ctl(f_ctl), .push_addr(f_addr), .push_hdr(f_hdr), .push_need(f_need),
      .base_latch(base_latch), .span_latch(span_latch)
   );

   // classified requests wait here while the sequencer is busy
   bfha_queue #(.W(QW)) u_queue (
      .clock(clock), .reset(reset),
      .in_valid(push), .in_ready(push_ready), .in_data({f_ctl, f_addr, f_hdr, f_need}),
      .out_valid(q_valid), .out_pop(q_pop), .out_data(q_out)
   );

   assign {b_ctl, b_addr, b_hdr, b_need} = q_out;

   bfha_back #(
      .HEAP_BYTES(HEAP_BYTES), .MAX_FREE_SEGS(MAX_FREE_SEGS), .MIN_SPLIT(MIN_SPLIT)
   ) u_back (
      .clock(clock), .reset(reset),
      .item_valid(q_valid), .item_pop(q_pop),
      .item_ctl(b_ctl), .item_addr(b_addr), .item_hdr(b_hdr), .item_need(b_need),
      .base_latch(base_latch), .span_latch(span_latch),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready),
      .rsp_status(r_status), .rsp_addr(r_addr), .rsp_moved(r_moved), .rsp_free(r_free)
   );

   assign rsp_tdata = {4'b0000, r_free, r_moved, r_addr, r_status};

endmodule

[rtl/bfha_front.sv]
// Front end: config registers, request intake, region check and size rounding.
// Depends on bfha_pkg.
module bfha_front #(
   parameter int HEAP_BYTES = bfha_pkg::DEF_HEAP_BYTES,
   parameter int OFF_W      = $clog2(HEAP_BYTES + 1),
   parameter int NEED_W     = OFF_W + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic                          csr_addr,
   input  logic [bfha_pkg::CSR_W-1:0]    csr_wdata,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic                          has_block,
   input  logic [bfha_pkg::ADDR_W-1:0]   block_addr,
   input  logic [bfha_pkg::SIZE_W-1:0]   req_size,
   output logic                          push,
   input  logic                          push_ready,
   output bfha_pkg::ctl_type             push_ctl,
   output logic [bfha_pkg::ADDR_W-1:0]   push_addr,
   output logic [OFF_W-1:0]              push_hdr,
   output logic [NEED_W-1:0]             push_need,
   output logic [bfha_pkg::ADDR_W-1:0]   base_latch,
   output logic [OFF_W-1:0]              span_latch
);

   logic [bfha_pkg::CSR_W-1:0]  base_cfg_ff, limit_cfg_ff;
   logic                        init_ff;
   logic [bfha_pkg::ADDR_W-1:0] base_ff;
   logic [OFF_W-1:0]            span_ff;
   logic                        v_ff, has_ff, first_ff;
   logic [bfha_pkg::ADDR_W-1:0] addr_ff;
   logic [bfha_pkg::SIZE_W-1:0] size_ff;

   logic [bfha_pkg::ADDR_W-1:0] diff, off;
   logic [OFF_W-1:0]            span_c;
   logic                        accept, bad;
   logic [bfha_pkg::SIZE_W:0]   rnd;

   assign accept     = req_tvalid && req_tready;
   assign push       = v_ff;
   assign req_tready = !v_ff || push_ready;
   assign base_latch = base_ff;
   assign span_latch = span_ff;

   // span = limit - base, saturated and word aligned
   always_comb begin
      diff = limit_cfg_ff - base_cfg_ff;
      if (limit_cfg_ff <= base_cfg_ff) begin
         span_c = '0;
      end else if (diff > bfha_pkg::ADDR_W'(HEAP_BYTES)) begin
         span_c = OFF_W'(HEAP_BYTES);
      end else begin
         span_c = diff[OFF_W-1:0];
      end
      span_c[1:0] = 2'b00;
   end

   always_comb begin
      off = addr_ff - base_ff;
      bad = (addr_ff < base_ff) || (off >= bfha_pkg::ADDR_W'(span_ff)) ||
            (off < bfha_pkg::ADDR_W'(4)) || (off[1:0] != 2'b00);
      rnd = {1'b0, size_ff} + (bfha_pkg::SIZE_W+1)'(7);
      if (size_ff > bfha_pkg::SIZE_W'(HEAP_BYTES)) begin
         push_need = NEED_W'(HEAP_BYTES + 4);
      end else begin
         push_need = {rnd[NEED_W-1:2], 2'b00};
      end
      push_hdr  = off[OFF_W-1:0] - OFF_W'(4);
      push_addr = addr_ff;
      push_ctl.first = first_ff;
      if (size_ff == '0) begin
         push_ctl.kind = !has_ff ? bfha_pkg::KIND_NULL :
                         (bad ? bfha_pkg::KIND_BAD : bfha_pkg::KIND_FREE);
      end else begin
         push_ctl.kind = !has_ff ? bfha_pkg::KIND_ALLOC :
                         (bad ? bfha_pkg::KIND_BAD : bfha_pkg::KIND_REALLOC);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_cfg_ff  <= bfha_pkg::HEAP_BASE_RST;
         limit_cfg_ff <= bfha_pkg::HEAP_LIMIT_RST;
         init_ff      <= 1'b0;
         v_ff         <= 1'b0;
      end else begin
         if (csr_we && csr_addr == bfha_pkg::CSR_HEAP_BASE) base_cfg_ff <= csr_wdata;
         if (csr_we && csr_addr == bfha_pkg::CSR_HEAP_LIMIT) limit_cfg_ff <= csr_wdata;
         if (accept) begin
            v_ff <= 1'b1;
            if (!init_ff) init_ff <= 1'b1;
         end else if (push_ready) begin
            v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         has_ff   <= has_block;
         addr_ff  <= block_addr;
         size_ff  <= req_size;
         first_ff <= !init_ff;
         if (!init_ff) begin
            base_ff <= base_cfg_ff;
            span_ff <= span_c;
         end
      end
   end

endmodule

[rtl/bfha_queue.sv]
// Two-entry queue between front and back end.
// No dependencies.
module bfha_queue #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [W-1:0] in_data,
   output logic         out_valid,
   input  logic         out_pop,
   output logic [W-1:0] out_data
);

   logic [W-1:0] slot_ff [2];
   logic         wr_ff, rd_ff;
   logic [1:0]   cnt_ff;
   logic         wr, rd;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_data  = slot_ff[rd_ff];
   assign wr        = in_valid && in_ready;
   assign rd        = out_pop && out_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (wr) wr_ff <= !wr_ff;
         if (rd) rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + {1'b0, wr} - {1'b0, rd};
      end
   end

   always_ff @(posedge clock) begin
      if (wr) slot_ff[wr_ff] <= in_data;
   end

endmodule

[rtl/bfha_back.sv]
// Back end: segment table, block size store and the allocate/free sequencer.
// Depends on bfha_pkg.
module bfha_back #(
   parameter int HEAP_BYTES    = bfha_pkg::DEF_HEAP_BYTES,
   parameter int MAX_FREE_SEGS = bfha_pkg::DEF_MAX_FREE_SEGS,
   parameter int MIN_SPLIT     = bfha_pkg::DEF_MIN_SPLIT,
   parameter int OFF_W         = $clog2(HEAP_BYTES + 1),
   parameter int NEED_W        = OFF_W + 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            item_valid,
   output logic                            item_pop,
   input  bfha_pkg::ctl_type               item_ctl,
   input  logic [bfha_pkg::ADDR_W-1:0]     item_addr,
   input  logic [OFF_W-1:0]                item_hdr,
   input  logic [NEED_W-1:0]               item_need,
   input  logic [bfha_pkg::ADDR_W-1:0]     base_latch,
   input  logic [OFF_W-1:0]                span_latch,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [bfha_pkg::STATUS_W-1:0]   rsp_status,
   output logic [bfha_pkg::ADDR_W-1:0]     rsp_addr,
   output logic                            rsp_moved,
   output logic [bfha_pkg::FREE_W-1:0]     rsp_free
);

   localparam int IW        = (MAX_FREE_SEGS > 1) ? $clog2(MAX_FREE_SEGS) : 1;
   localparam int CW        = $clog2(MAX_FREE_SEGS + 1);
   localparam int BLK_WORDS = (HEAP_BYTES + 3) / 4;
   localparam int BW        = $clog2(BLK_WORDS);
   localparam int SUM_W     = OFF_W + 1;
   localparam int EXT_W     = SUM_W + CW + 2;

   typedef enum logic [3:0] {
      ST_IDLE, ST_INIT, ST_DISPATCH, ST_G_GO, ST_G_SCAN, ST_G_DO,
      ST_REL_GO, ST_REL_SCAN, ST_REL_DO, ST_SH_RD, ST_SH_WR, ST_DONE
   } state_type;

   function automatic logic [OFF_W-1:0] sat(input logic [OFF_W+1:0] v);
      return (v > (OFF_W+2)'(HEAP_BYTES)) ? OFF_W'(HEAP_BYTES) : v[OFF_W-1:0];
   endfunction

   // storage
   logic [OFF_W-1:0] seg_s_mem [MAX_FREE_SEGS];
   logic [OFF_W-1:0] seg_l_mem [MAX_FREE_SEGS];
   logic [OFF_W-1:0] blk_mem   [BLK_WORDS];
   logic [OFF_W-1:0] sd_ff, ld_ff, blk_rd_ff;

   logic             we_s, we_l, bwe;
   logic [IW-1:0]    waddr, raddr;
   logic [OFF_W-1:0] ws, wl, bdata;
   logic [BW-1:0]    baddr;

   state_type                    state_ff, state_in;
   bfha_pkg::kind_type           kind_ff, kind_in;
   logic                         first_ff, first_in;
   logic [bfha_pkg::ADDR_W-1:0]  addr_ff, addr_in;
   logic [OFF_W-1:0]             hdr_ff, hdr_in;
   logic [NEED_W-1:0]            need_ff, need_in;
   logic                         relph_ff, relph_in;
   logic [CW-1:0]                cnt_ff, cnt_in;
   logic [SUM_W-1:0]             sum_ff, sum_in;
   logic [CW-1:0]                scan_ff, scan_in, ev_idx_ff, ev_idx_in;
   logic                         ev_v_ff, ev_v_in;
   logic                         found_ff, found_in;
   logic [CW-1:0]                best_ff, best_in;
   logic [OFF_W-1:0]             best_s_ff, best_s_in, best_l_ff, best_l_in;
   logic                         prev_v_ff, prev_v_in, cur_v_ff, cur_v_in;
   logic [OFF_W-1:0]             prev_s_ff, prev_s_in, prev_l_ff, prev_l_in;
   logic [OFF_W-1:0]             cur_s_ff, cur_s_in, cur_l_ff, cur_l_in;
   logic [CW-1:0]                ins_ff, ins_in, k_ff, k_in;
   logic [OFF_W-1:0]             rlen_ff, rlen_in;
   logic                         dn_ff, dn_in;
   bfha_pkg::status_type         status_ff, status_in;
   logic [bfha_pkg::ADDR_W-1:0]  res_ff, res_in;
   logic                         moved_ff, moved_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [bfha_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [bfha_pkg::ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;
   logic                         rsp_moved_ff, rsp_moved_in;
   logic [bfha_pkg::FREE_W-1:0]  rsp_free_ff, rsp_free_in;

   // helpers
   logic                    fits, better, exact, whole, lo, hi, load;
   logic [OFF_W-1:0]        remain, blk, blen, merged;
   logic [NEED_W:0]         need_split;
   logic [EXT_W-1:0]        sum_e, dec_e, fdiff;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_addr   = rsp_addr_ff;
   assign rsp_moved  = rsp_moved_ff;
   assign rsp_free   = rsp_free_ff;
   assign item_pop   = (state_ff == ST_IDLE) && item_valid;
   assign load       = !rsp_valid_ff || rsp_ready;
   assign baddr      = bwe ? blk[BW+1:2] : hdr_ff[BW+1:2];

   always_comb begin
      fits       = {1'b0, ld_ff} >= need_ff;
      better     = ev_v_ff && fits && (!found_ff || ld_ff < best_l_ff);
      exact      = better && ({1'b0, ld_ff} == need_ff);
      need_split = {1'b0, need_ff} + (NEED_W+1)'(MIN_SPLIT);
      whole      = (NEED_W+1)'(best_l_ff) <= need_split;
      remain     = best_l_ff - need_ff[OFF_W-1:0];
      blk        = whole ? best_s_ff : best_s_ff + remain;
      blen       = whole ? best_l_ff : need_ff[OFF_W-1:0];
      lo = prev_v_ff && ((OFF_W+1)'(prev_s_ff) + (OFF_W+1)'(prev_l_ff) == (OFF_W+1)'(hdr_ff));
      hi = cur_v_ff && ((OFF_W+1)'(hdr_ff) + (OFF_W+1)'(rlen_ff) == (OFF_W+1)'(cur_s_ff));
      merged = sat((OFF_W+2)'(lo ? prev_l_ff : '0) + (OFF_W+2)'(rlen_ff) +
                   (OFF_W+2)'(hi ? cur_l_ff : '0));
      sum_e  = EXT_W'(sum_ff);
      dec_e  = EXT_W'({cnt_ff, 2'b00});
      fdiff  = sum_e - dec_e;
   end

   always_comb begin
      state_in = state_ff;   kind_in = kind_ff;     first_in = first_ff;
      addr_in = addr_ff;     hdr_in = hdr_ff;       need_in = need_ff;
      relph_in = relph_ff;   cnt_in = cnt_ff;       sum_in = sum_ff;
      scan_in = scan_ff + CW'(1);
      ev_idx_in = scan_ff;
      ev_v_in = scan_ff < cnt_ff;
      found_in = found_ff;   best_in = best_ff;     best_s_in = best_s_ff;
      best_l_in = best_l_ff; prev_v_in = prev_v_ff; prev_s_in = prev_s_ff;
      prev_l_in = prev_l_ff; cur_v_in = cur_v_ff;   cur_s_in = cur_s_ff;
      cur_l_in = cur_l_ff;   ins_in = ins_ff;       k_in = k_ff;
      rlen_in = rlen_ff;     dn_in = dn_ff;         status_in = status_ff;
      res_in = res_ff;       moved_in = moved_ff;
      rsp_status_in = rsp_status_ff; rsp_addr_in = rsp_addr_ff;
      rsp_moved_in = rsp_moved_ff;   rsp_free_in = rsp_free_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      we_s = 1'b0; we_l = 1'b0; bwe = 1'b0;
      waddr = '0; ws = '0; wl = '0; bdata = blen;
      raddr = scan_ff[IW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               kind_in   = item_ctl.kind;
               first_in  = item_ctl.first;
               addr_in   = item_addr;
               hdr_in    = item_hdr;
               need_in   = item_need;
               relph_in  = 1'b0;
               status_in = bfha_pkg::STATUS_OK;
               res_in    = '0;
               moved_in  = 1'b0;
               state_in  = ST_INIT;
            end
         end
         ST_INIT: begin
            if (first_ff) begin
               if (span_latch != '0) begin
                  we_s = 1'b1; we_l = 1'b1; waddr = '0; ws = '0; wl = span_latch;
                  cnt_in = CW'(1);
                  sum_in = SUM_W'(span_latch);
               end else begin
                  cnt_in = '0;
                  sum_in = '0;
               end
            end
            state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            // size word of the named block; the store port is reused by the allocation
            rlen_in = blk_rd_ff;
            case (kind_ff)
               bfha_pkg::KIND_FREE:  state_in = ST_REL_GO;
               bfha_pkg::KIND_ALLOC: state_in = ST_G_GO;
               bfha_pkg::KIND_REALLOC: begin
                  if (need_ff <= NEED_W'(blk_rd_ff)) begin
                     res_in   = addr_ff;
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_G_GO;
                  end
               end
               bfha_pkg::KIND_BAD: begin
                  status_in = bfha_pkg::STATUS_OUTSIDE;
                  state_in  = ST_DONE;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_G_GO: begin
            found_in = 1'b0;
            scan_in  = '0;
            ev_v_in  = 1'b0;
            state_in = (cnt_ff == '0) ? ST_G_DO : ST_G_SCAN;
         end
         ST_G_SCAN: begin
            if (better) begin
               found_in  = 1'b1;
               best_in   = ev_idx_ff;
               best_s_in = sd_ff;
               best_l_in = ld_ff;
            end
            if (ev_v_ff && (exact || ev_idx_ff == cnt_ff - CW'(1))) state_in = ST_G_DO;
         end
         ST_G_DO: begin
            if (!found_ff) begin
               status_in = bfha_pkg::STATUS_NO_SPACE;
               state_in  = ST_DONE;
            end else begin
               bwe      = 1'b1;
               sum_in   = sum_ff - SUM_W'(blen);
               res_in   = base_latch + bfha_pkg::ADDR_W'(blk) + bfha_pkg::ADDR_W'(4);
               moved_in = kind_ff == bfha_pkg::KIND_REALLOC;
               if (whole) begin
                  dn_in    = 1'b1;
                  k_in     = best_ff;
                  state_in = ST_SH_RD;
               end else begin
                  we_l     = 1'b1;
                  waddr    = best_ff[IW-1:0];
                  wl       = remain;
                  state_in = (kind_ff == bfha_pkg::KIND_REALLOC) ? ST_REL_GO : ST_DONE;
               end
            end
         end
         ST_REL_GO: begin
            relph_in  = 1'b1;
            prev_v_in = 1'b0;
            cur_v_in  = 1'b0;
            ins_in    = cnt_ff;
            scan_in   = '0;
            ev_v_in   = 1'b0;
            state_in  = (cnt_ff == '0) ? ST_REL_DO : ST_REL_SCAN;
         end
         ST_REL_SCAN: begin
            if (ev_v_ff) begin
               if (hdr_ff > sd_ff) begin
                  prev_v_in = 1'b1;
                  prev_s_in = sd_ff;
                  prev_l_in = ld_ff;
                  if (ev_idx_ff == cnt_ff - CW'(1)) begin
                     ins_in   = cnt_ff;
                     state_in = ST_REL_DO;
                  end
               end else begin
                  cur_v_in = 1'b1;
                  cur_s_in = sd_ff;
                  cur_l_in = ld_ff;
                  ins_in   = ev_idx_ff;
                  state_in = ST_REL_DO;
               end
            end
         end
         ST_REL_DO: begin
            state_in = ST_DONE;
            if (lo || hi) begin
               sum_in = sum_ff - SUM_W'(lo ? prev_l_ff : '0) - SUM_W'(hi ? cur_l_ff : '0) +
                        SUM_W'(merged);
            end
            if (lo) begin
               // merge into the lower neighbor; absorb the upper one as well if touching
               we_l  = 1'b1;
               waddr = IW'(ins_ff - CW'(1));
               wl    = merged;
               if (hi) begin
                  dn_in    = 1'b1;
                  k_in     = ins_ff;
                  state_in = ST_SH_RD;
               end
            end else if (hi) begin
               we_s  = 1'b1; we_l = 1'b1;
               waddr = ins_ff[IW-1:0];
               ws    = hdr_ff;
               wl    = merged;
            end else if (cnt_ff >= CW'(MAX_FREE_SEGS)) begin
               status_in = bfha_pkg::STATUS_TABLE_FULL;
            end else begin
               dn_in    = 1'b0;
               k_in     = cnt_ff;
               state_in = ST_SH_RD;
            end
         end
         ST_SH_RD: begin
            raddr = dn_ff ? IW'(k_ff + CW'(1)) : IW'(k_ff - CW'(1));
            if (dn_ff) begin
               if (k_ff + CW'(1) < cnt_ff) begin
                  state_in = ST_SH_WR;
               end else begin
                  cnt_in   = cnt_ff - CW'(1);
                  state_in = (!relph_ff && kind_ff == bfha_pkg::KIND_REALLOC) ?
                             ST_REL_GO : ST_DONE;
               end
            end else if (k_ff > ins_ff) begin
               state_in = ST_SH_WR;
            end else begin
               we_s = 1'b1; we_l = 1'b1;
               waddr  = ins_ff[IW-1:0];
               ws     = hdr_ff;
               wl     = rlen_ff;
               cnt_in = cnt_ff + CW'(1);
               sum_in = sum_ff + SUM_W'(rlen_ff);
               state_in = ST_DONE;
            end
         end
         ST_SH_WR: begin
            we_s = 1'b1; we_l = 1'b1;
            waddr = k_ff[IW-1:0];
            ws    = sd_ff;
            wl    = ld_ff;
            k_in  = dn_ff ? k_ff + CW'(1) : k_ff - CW'(1);
            state_in = ST_SH_RD;
         end
         ST_DONE: begin
            if (load) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_addr_in   = res_ff;
               rsp_moved_in  = moved_ff;
               if (sum_e <= dec_e) begin
                  rsp_free_in = '0;
               end else if (fdiff > EXT_W'({bfha_pkg::FREE_W{1'b1}})) begin
                  rsp_free_in = '1;
               end else begin
                  rsp_free_in = fdiff[bfha_pkg::FREE_W-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff <= kind_in;     first_ff <= first_in;   addr_ff <= addr_in;
      hdr_ff <= hdr_in;       need_ff <= need_in;     relph_ff <= relph_in;
      scan_ff <= scan_in;     ev_idx_ff <= ev_idx_in; ev_v_ff <= ev_v_in;
      found_ff <= found_in;   best_ff <= best_in;     best_s_ff <= best_s_in;
      best_l_ff <= best_l_in; prev_v_ff <= prev_v_in; prev_s_ff <= prev_s_in;
      prev_l_ff <= prev_l_in; cur_v_ff <= cur_v_in;   cur_s_ff <= cur_s_in;
      cur_l_ff <= cur_l_in;   ins_ff <= ins_in;       k_ff <= k_in;
      rlen_ff <= rlen_in;     dn_ff <= dn_in;         status_ff <= status_in;
      res_ff <= res_in;       moved_ff <= moved_in;
      rsp_status_ff <= rsp_status_in; rsp_addr_ff <= rsp_addr_in;
      rsp_moved_ff <= rsp_moved_in;   rsp_free_ff <= rsp_free_in;
   end

   always_ff @(posedge clock) begin
      if (we_s) seg_s_mem[waddr] <= ws;
      if (we_l) seg_l_mem[waddr] <= wl;
      sd_ff <= seg_s_mem[raddr];
      ld_ff <= seg_l_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (bwe) blk_mem[baddr] <= bdata;
      blk_rd_ff <= blk_mem[baddr];
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_FREE_SEGS))
      else $error("segment count above table size");

   a_best_fits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_G_DO && found_ff) |-> ({1'b0, best_l_ff} >= need_ff))
      else $error("chosen segment too small");

   a_full_code: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && status_ff == bfha_pkg::STATUS_TABLE_FULL) |->
      (cnt_ff == CW'(MAX_FREE_SEGS)))
      else $error("table-full reported with room left");

endmodule

[bench/best_fit_heap_allocator_tb.sv]
// Self-checking bench for best_fit_heap_allocator: directed and random alloc/free/realloc
// beats, checked against an in-bench best-fit free-list predictor.
// Depends on rtl/bfha_pkg.sv and rtl/best_fit_heap_allocator.sv.
`timescale 1ns / 100ps
module best_fit_heap_allocator_tb;

   localparam int HEAP      = bfha_pkg::DEF_HEAP_BYTES;
   localparam int SEGS      = bfha_pkg::DEF_MAX_FREE_SEGS;
   localparam int SPLIT_MAX = bfha_pkg::DEF_MIN_SPLIT;
   localparam int WORDS     = HEAP / 4;
   localparam int DRAIN_CYC = 400;

   typedef struct {
      bit          has;
      logic [31:0] addr;
      logic [31:0] size;
      bit          hold;    // wait for every result before sending
      bit          calm;    // no idling on either side for this beat
   } heap_req_type;

   typedef struct {
      bfha_pkg::status_type status;
      logic [31:0] addr;
      bit          moved;
      logic [16:0] free;
   } heap_rsp_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic        csr_addr = bfha_pkg::CSR_HEAP_BASE;
   logic [31:0] csr_wdata = '0;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // block_addr[31:0], req_size[63:32]
   logic        req_tuser = 0;    // has_block
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [55:0] rsp_tdata;        // status[1:0], result_addr[33:2], moved[34],
                                  // free_bytes[51:35], zero[55:52]

   best_fit_heap_allocator dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // ---------------------------------------------------------------- predictor
   // Own copy of the allocator state. Config is only latched on the first
   // request after reset; later writes are kept but never take effect.
   logic [31:0]     cfg_base = bfha_pkg::HEAP_BASE_RST, cfg_limit = bfha_pkg::HEAP_LIMIT_RST;
   bit              latched = 0;
   logic [31:0]     base_q;
   longint unsigned span_q;
   longint unsigned seg_off[SEGS], seg_len[SEGS];
   int              nseg = 0;
   longint unsigned blk_len[WORDS];

   function automatic longint unsigned clamp_heap(longint unsigned v);
      return v > HEAP ? HEAP : v;
   endfunction

   function automatic void drop_segment(int i);
      for (int k = i; k + 1 < nseg; k++) begin
         seg_off[k] = seg_off[k+1];
         seg_len[k] = seg_len[k+1];
      end
      if (nseg > 0) nseg--;
   endfunction

   // data address -> header offset; 0 when outside the region
   function automatic bit locate_hdr(logic [31:0] a, output longint unsigned hdr);
      longint unsigned off;
      hdr = 0;
      if (a < base_q) return 0;
      off = a - base_q;
      if (off >= span_q || off < 4 || off[1:0] != 0) return 0;
      hdr = off - 4;
      return 1;
   endfunction

   function automatic bfha_pkg::status_type give_back(longint unsigned hdr);
      longint unsigned len;
      int i;
      bit lo, hi;
      len = blk_len[hdr >> 2];
      i = 0;
      while (i < nseg && hdr > seg_off[i]) i++;
      lo = i > 0 && seg_off[i-1] + seg_len[i-1] == hdr;
      hi = i < nseg && hdr + len == seg_off[i];
      if (lo && hi) begin
         seg_len[i-1] = clamp_heap(seg_len[i-1] + len + seg_len[i]);
         drop_segment(i);
      end else if (lo) begin
         seg_len[i-1] = clamp_heap(seg_len[i-1] + len);
      end else if (hi) begin
         seg_off[i] = hdr;
         seg_len[i] = clamp_heap(len + seg_len[i]);
      end else begin
         if (nseg >= SEGS) return bfha_pkg::STATUS_TABLE_FULL;
         for (int k = nseg; k > i; k--) begin
            seg_off[k] = seg_off[k-1];
            seg_len[k] = seg_len[k-1];
         end
         seg_off[i] = hdr;
         seg_len[i] = len;
         nseg++;
      end
      return bfha_pkg::STATUS_OK;
   endfunction

   function automatic bfha_pkg::status_type take_best_fit(longint unsigned need,
                                                          output logic [31:0] a);
      int best;
      bit found;
      longint unsigned blk;
      a = '0;
      best = 0;
      found = 0;
      for (int i = 0; i < nseg; i++) begin
         if (seg_len[i] >= need && (!found || seg_len[i] < seg_len[best])) begin
            found = 1;
            best = i;
            if (seg_len[i] == need) break;
         end
      end
      if (!found) return bfha_pkg::STATUS_NO_SPACE;
      if (seg_len[best] <= need + SPLIT_MAX) begin
         // leftover too small to keep: hand out the whole segment
         blk = seg_off[best];
         blk_len[blk >> 2] = seg_len[best];
         drop_segment(best);
      end else begin
         seg_len[best] -= need;
         blk = seg_off[best] + seg_len[best];
         blk_len[blk >> 2] = need;
      end
      a = base_q + 32'(blk) + 32'd4;
      return bfha_pkg::STATUS_OK;
   endfunction

   function automatic logic [16:0] free_sum();
      longint unsigned sum, dec;
      sum = 0;
      dec = 4 * nseg;
      for (int i = 0; i < nseg; i++) sum += seg_len[i];
      if (sum <= dec) return '0;
      sum -= dec;
      return sum > 131071 ? 17'h1FFFF : 17'(sum);
   endfunction

   function automatic heap_rsp_type predict_heap(bit has, logic [31:0] a, logic [31:0] sz);
      heap_rsp_type r;
      longint unsigned need, hdr, span;
      r.status = bfha_pkg::STATUS_OK;
      r.addr = '0;
      r.moved = 0;
      need = (longint'(sz) + 7) & ~64'd3;
      if (!latched) begin
         span = cfg_limit > cfg_base ? cfg_limit - cfg_base : 0;
         if (span > HEAP) span = HEAP;
         span &= ~64'd3;
         latched = 1;
         base_q = cfg_base;
         span_q = span;
         nseg = 0;
         if (span != 0) begin
            seg_off[0] = 0;
            seg_len[0] = span;
            nseg = 1;
         end
      end
      if (sz == 0) begin
         if (has) r.status = locate_hdr(a, hdr) ? give_back(hdr) : bfha_pkg::STATUS_OUTSIDE;
      end else if (has) begin
         if (!locate_hdr(a, hdr)) r.status = bfha_pkg::STATUS_OUTSIDE;
         else if (need <= blk_len[hdr >> 2]) r.addr = a;
         else begin
            r.status = take_best_fit(need, r.addr);
            if (r.status == bfha_pkg::STATUS_OK) begin
               r.moved = 1;
               r.status = give_back(hdr);
            end
         end
      end else begin
         r.status = take_best_fit(need, r.addr);
      end
      r.free = free_sum();
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus store
   heap_req_type pend_q[$];
   heap_rsp_type exp_q[$];
   logic [31:0]  live[$];      // data addresses currently owned by the caller
   int           n_sent = 0, n_got = 0, n_err = 0;
   bit           quiet = 0;

   // queue a beat, predict it and track which blocks are live
   task automatic issue(bit has, logic [31:0] a, logic [31:0] sz, bit hold = 0,
                        bit calm = 0);
      heap_rsp_type r;
      int idx[$];
      r = predict_heap(has, a, sz);
      pend_q.push_back('{has, a, sz, hold, calm});
      exp_q.push_back(r);
      if (has && r.status != bfha_pkg::STATUS_OUTSIDE && (sz == 0 || r.moved)) begin
         // a freed (or moved-away) block leaves the live list unless table was full on move
         if (sz == 0 || r.status == bfha_pkg::STATUS_OK) begin
            idx = live.find_first_index(x) with (x == a);
            if (idx.size() != 0) live.delete(idx[0]);
         end
      end
      if (r.addr != 0 && r.addr != a) live.push_back(r.addr);
      if (!has && sz != 0 && r.status == bfha_pkg::STATUS_OK) begin
      end
   endtask

   function automatic logic [31:0] pick_size();
      int roll;
      roll = $urandom_range(99);
      if (roll < 70) return $urandom_range(1, 64);
      if (roll < 95) return $urandom_range(65, 4096);
      if (roll < 98) return $urandom_range(4097, 40000);
      return $urandom;
   endfunction

   // address the block rejects: below the base, or misaligned inside the region
   function automatic logic [31:0] stray_addr();
      if ($urandom_range(1)) return $urandom & 32'h7FFF_FFFF;
      return base_q + ($urandom_range(4, 65000) & ~32'd3) + $urandom_range(1, 3);
   endfunction

   task automatic wait_idle();
      wait (pend_q.size() == 0 && n_got == n_sent);
      repeat (DRAIN_CYC) @(posedge clock);
   endtask

   task automatic csr_write(bfha_pkg::csr_idx_type idx, logic [31:0] v);
      @(negedge clock);
      csr_we <= 1;
      csr_addr <= idx;
      csr_wdata <= v;
      if (idx == bfha_pkg::CSR_HEAP_BASE) cfg_base = v;
      else cfg_limit = v;
      @(negedge clock);
      csr_we <= 0;
   endtask

   task automatic run_random(int count);
      int roll, j, k;
      logic [31:0] a;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         if (roll < 3 && live.size() < 60) begin
            // fragment the heap: small blocks, then free every other one of the newest 150,
            // which can overflow the segment table, then grow up to four survivors
            for (j = 0; j < 150; j++) issue(0, '0, $urandom_range(1, 20));
            k = live.size();
            for (j = k - 1; j >= 0 && j >= k - 150; j -= 2) issue(1, live[j], 0);
            for (j = 0; j < 4 && live.size() > 0; j++)
               issue(1, live[$urandom_range(live.size() - 1)], $urandom_range(100, 400));
            n += 200;
         end else if (roll < 8) begin
            case ($urandom_range(2))
               0: issue(0, $urandom, 0);
               1: issue(1, stray_addr(), 0);
               default: issue(1, stray_addr(), pick_size());
            endcase
         end else if (live.size() == 0 || (roll < 50 && live.size() < 150)) begin
            issue(0, '0, pick_size());
         end else if (roll < 80 || live.size() >= 150) begin
            issue(1, live[$urandom_range(live.size() - 1)], 0);
         end else begin
            a = live[$urandom_range(live.size() - 1)];
            issue(1, a, $urandom_range(1) ? pick_size() : $urandom_range(1, 8));
         end
      end
   endtask

   initial begin
      logic [31:0] a1, a2, a3;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // top of the address space: span is just under 64 KB (65532 bytes)
      csr_write(bfha_pkg::CSR_HEAP_BASE, 32'hFFFF_0000);
      csr_write(bfha_pkg::CSR_HEAP_LIMIT, 32'hFFFF_FFFF);

      // directed
      issue(0, '0, '0);                          // null request
      issue(0, '0, 32'd1);
      a1 = live[$];
      issue(0, '0, 32'hFFFF_FFFF);               // no space, 64-bit need
      issue(0, '0, 32'd65528);                   // no space
      issue(1, 32'h0, 0);                        // below base
      issue(1, 32'hFFFF_0000, 0);                // first word of region
      issue(1, 32'hFFFF_0006, 0);                // misaligned
      issue(1, 32'hFFFF_FFFF, 0);                // past the end
      issue(1, 32'h0000_0010, 32'd8);            // realloc outside
      issue(1, a1, 32'd2);                       // realloc that fits
      issue(1, a1, 32'hFFFF_FFFF, 1);            // realloc no space, sender pauses
      issue(1, a1, 32'd100);                     // realloc that moves
      a1 = live[$];
      issue(0, '0, 32'd40);
      a2 = live[$];
      issue(0, '0, 32'd40);
      a3 = live[$];
      issue(1, a2, 0);                           // free, no neighbor
      issue(0, '0, 32'd40);                      // exact fit into the hole
      a2 = live[$];
      issue(1, a3, 0);
      issue(1, a2, 0);                           // merge with the lower neighbor
      issue(0, '0, 32'd65400);                   // splits the big segment, leaving 16 bytes
      issue(1, live[$], 0);
      issue(1, a1, 0);
      issue(0, '0, 32'd3);
      issue(1, live[$], 0);

      run_random(450);
      wait_idle();
      // registers only matter after a reset; still exercise the port at extremes
      csr_write(bfha_pkg::CSR_HEAP_BASE, 32'h0000_0000);
      csr_write(bfha_pkg::CSR_HEAP_LIMIT, 32'hFFFF_FFFF);
      csr_write(bfha_pkg::CSR_HEAP_LIMIT, 32'h0000_0000);

      for (int n = 0; n < 120; n++) begin
         if (live.size() == 0 || $urandom_range(1)) issue(0, '0, pick_size(), 0, 1);
         else issue(1, live[$urandom_range(live.size() - 1)], 0, 0, 1);
      end
      issue(0, '0, 32'd4, 1);                    // pause until all results are in
      run_random(330);

      wait_idle();
      if (n_err == 0 && exp_q.size() == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   initial begin
      #50ms;
      $display("TEST FAILED");
      $finish;
   end

   // ---------------------------------------------------------------- request driver
   bit           req_taken = 0;
   heap_req_type cur;

   always @(posedge clock) begin
      req_taken <= req_tvalid && req_tready;
      if (req_tvalid && req_tready) n_sent <= n_sent + 1;
   end

   // new beat goes out at the falling edge once the previous one was taken
   always @(negedge clock) begin
      if (!reset && !(req_tvalid && !req_taken)) begin
         if (pend_q.size() != 0 && (pend_q[0].calm || $urandom_range(99) >= 24) &&
             !(pend_q[0].hold && n_got != n_sent)) begin
            cur = pend_q.pop_front();
            req_tvalid <= 1;
            req_tuser  <= cur.has;
            req_tdata  <= {cur.size, cur.addr};
            quiet      <= cur.calm;
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   // ---------------------------------------------------------------- result monitor
   always @(negedge clock) begin
      rsp_tready <= !reset && (quiet || $urandom_range(99) >= 24);
   end

   task automatic flag_mismatch(string what, longint got, longint want);
      $display("result %0d: %s got 0x%0h expected 0x%0h", n_got, what, got, want);
      n_err++;
   endtask

   heap_rsp_type want;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (exp_q.size() == 0 || n_got >= n_sent) begin
            flag_mismatch("unexpected beat", rsp_tdata, 0);
         end else begin
            want = exp_q.pop_front();
            if (rsp_tdata[1:0] != want.status)
               flag_mismatch("status", rsp_tdata[1:0], want.status);
            if (rsp_tdata[33:2] != want.addr)
               flag_mismatch("result_addr", rsp_tdata[33:2], want.addr);
            if (rsp_tdata[34] != want.moved)
               flag_mismatch("moved", rsp_tdata[34], want.moved);
            if (rsp_tdata[51:35] != want.free)
               flag_mismatch("free_bytes", rsp_tdata[51:35], want.free);
         end
         n_got <= n_got + 1;
      end
   end

endmodule
